### rtl/softmax_detection_product_assert.svh
// assertion macros for the softmax detection product checker
// needs aclk and aresetn in the scope where a macro is used
`ifndef SOFTMAX_DETECTION_PRODUCT_ASSERT_SVH
`define SOFTMAX_DETECTION_PRODUCT_ASSERT_SVH

// pre holds, then post holds at the next edge
`define SDP_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error("sdp check failed");

// pre holds, then post holds at the same edge
`define SDP_ASSERT_NOW(lbl, pre, post) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error("sdp check failed");

`endif

### rtl/sdp_pkg.sv
// shared widths and constants for the softmax detection product
// no dependencies
package sdp_pkg;
    localparam int CLS_W   = 2;
    localparam int LOGIT_W = 16;
    localparam int PROB_W  = 17;
    localparam logic [PROB_W-1:0] ONE_Q16 = 17'h10000;
endpackage

### rtl/softmax_detection_product.sv
// softmax detection product: per-site likelihood products over visits
// depends on sdp_pkg
//
//  channel  | ports                          | moves
//  ---------+--------------------------------+-------------------------------
//  s_       | s_valid s_ready, class, logits | one visit word
//  m_       | m_valid m_ready, prob_state0..3| one site word at end_of_site
//  cfg_     | cfg_we cfg_wdata               | four_state_mode, no wait
//
// one shared exp / divide / multiply datapath under a sequencer; per visit
// each softmax group with n logits computes n+1 exponentials, each from 16 series
// terms (two partial multiplies, six radix-256 divide-by-k steps per term)
// plus four squarings; a skipped visit runs none. s_ready is low while a
// visit is at work. the result sits in an output register, and a site end
// waits only while an earlier result is still untaken. reset is synchronous.
module softmax_detection_product (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic                        cfg_wdata,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [sdp_pkg::CLS_W-1:0]   s_observed_class,
    input  logic                        s_missing_visit,
    input  logic                        s_end_of_site,
    input  logic signed [15:0]          s_logit_a,
    input  logic signed [15:0]          s_logit_b,
    input  logic signed [15:0]          s_logit_c,
    input  logic signed [15:0]          s_logit_d,
    input  logic signed [15:0]          s_logit_e,
    input  logic signed [15:0]          s_logit_f,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [sdp_pkg::PROB_W-1:0]  m_prob_state0,
    output logic [sdp_pkg::PROB_W-1:0]  m_prob_state1,
    output logic [sdp_pkg::PROB_W-1:0]  m_prob_state2,
    output logic [sdp_pkg::PROB_W-1:0]  m_prob_state3
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_JOB   = 4'd1;
    localparam logic [3:0] S_EINIT = 4'd2;
    localparam logic [3:0] S_MLO   = 4'd3;
    localparam logic [3:0] S_MHI   = 4'd4;
    localparam logic [3:0] S_KDIV  = 4'd5;
    localparam logic [3:0] S_EFIN  = 4'd6;
    localparam logic [3:0] S_SQ    = 4'd7;
    localparam logic [3:0] S_ENEXT = 4'd8;
    localparam logic [3:0] S_QINIT = 4'd9;
    localparam logic [3:0] S_QDIV  = 4'd10;
    localparam logic [3:0] S_PMUL  = 4'd11;
    localparam logic [3:0] S_DONE  = 4'd12;

    localparam int PW = sdp_pkg::PROB_W;

    logic [3:0]  state_reg, state_next;
    logic        mode_reg, mode_next;
    logic [1:0]  cls_reg, cls_next;
    logic        last_reg, last_next;
    logic signed [15:0] lg_reg [6];
    logic signed [15:0] lg_next [6];
    logic [PW-1:0] prod_reg [4];
    logic [PW-1:0] prod_next [4];
    logic [1:0]  s_idx_reg, s_idx_next;
    logic [1:0]  j_reg, j_next;
    logic signed [15:0] m_reg, m_next;
    logic [15:0] d_reg, d_next;
    logic [40:0] term_reg, term_next;
    logic [41:0] pos_reg, pos_next;
    logic [41:0] neg_reg, neg_next;
    logic [4:0]  k_reg, k_next;
    logic [36:0] acc_reg, acc_next;
    logic [47:0] dv_reg, dv_next;
    logic [4:0]  rem_reg, rem_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [31:0] sq_reg, sq_next;
    logic [33:0] den_reg, den_next;
    logic [31:0] esel_reg, esel_next;
    logic [34:0] qrem_reg, qrem_next;
    logic [16:0] qn_reg, qn_next;
    logic [16:0] q_reg, q_next;
    logic [4:0]  qc_reg, qc_next;
    logic        mv_reg, mv_next;
    logic [PW-1:0] out_reg [4];
    logic [PW-1:0] out_next [4];

    // logit j of the group that feeds true state s, j = 0 is the implicit zero
    function automatic logic signed [15:0] pick(input logic signed [15:0] lg [6],
                                                input logic [1:0] s, input logic [1:0] j);
        logic signed [15:0] r;
        r = 16'sd0;
        case (s)
            2'd1: if (j == 2'd1) r = lg[0];
            2'd2: begin
                if (j == 2'd1) r = lg[1];
                else if (j == 2'd2) r = lg[2];
            end
            2'd3: begin
                if (j == 2'd1) r = lg[3];
                else if (j == 2'd2) r = lg[4];
                else if (j == 2'd3) r = lg[5];
            end
            default: r = 16'sd0;
        endcase
        return r;
    endfunction

    logic signed [15:0] gmax;
    logic [1:0]  sel;
    logic signed [16:0] diff;
    logic [56:0] mhi_sum;
    logic [5:0]  kr;
    logic [4:0]  krem;
    logic [7:0]  kq;
    logic [41:0] r_diff;
    logic [42:0] r_round;
    logic [63:0] sq_prod;
    logic [33:0] den_fix;
    logic [35:0] qr;
    logic [35:0] dd2;
    logic [33:0] pm;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = mv_reg;
    assign m_prob_state0 = out_reg[0];
    assign m_prob_state1 = out_reg[1];
    assign m_prob_state2 = out_reg[2];
    assign m_prob_state3 = out_reg[3];

    always_comb begin
        // group maximum including the implicit zero
        gmax = 16'sd0;
        for (int j = 1; j <= 3; j++) begin
            if (j <= int'(s_idx_reg) && pick(lg_reg, s_idx_reg, 2'(j)) > gmax)
                gmax = pick(lg_reg, s_idx_reg, 2'(j));
        end
        if (mode_reg)
            sel = (cls_reg == s_idx_reg) ? 2'd0 : cls_reg + 2'd1;
        else
            sel = (cls_reg == 2'd0) ? 2'd0 : 2'd1;
        diff = 17'(m_reg) - 17'(pick(lg_reg, s_idx_reg, j_reg));
        mhi_sum = {21'(term_reg[40:21]) * 36'(d_reg), 21'b0} + 57'(acc_reg);
        // eight restoring steps of the divide by k
        krem = rem_reg;
        kq = 8'd0;
        for (int b = 7; b >= 0; b--) begin
            kr = {krem, dv_reg[40 + b]};
            if (kr >= 6'(k_reg)) begin
                kr = kr - 6'(k_reg);
                kq[b] = 1'b1;
            end
            krem = kr[4:0];
        end
        r_diff = (pos_reg > neg_reg) ? pos_reg - neg_reg : 42'd0;
        r_round = 43'(r_diff) + 43'd512;
        sq_prod = 64'(sq_reg) * 64'(sq_reg) + 64'h2000_0000;
        den_fix = (den_reg == 34'd0) ? 34'd1 : den_reg;
        dd2 = {1'b0, den_reg, 1'b0};
        qr = {qrem_reg, qn_reg[16]};
        pm = 34'(prod_reg[s_idx_reg]) * 34'(q_reg) + 34'd32768;
    end

    always_comb begin
        state_next = state_reg;
        mode_next = cfg_we ? cfg_wdata : mode_reg;
        cls_next = cls_reg;
        last_next = last_reg;
        lg_next = lg_reg;
        prod_next = prod_reg;
        s_idx_next = s_idx_reg;
        j_next = j_reg;
        m_next = m_reg;
        d_next = d_reg;
        term_next = term_reg;
        pos_next = pos_reg;
        neg_next = neg_reg;
        k_next = k_reg;
        acc_next = acc_reg;
        dv_next = dv_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        sq_next = sq_reg;
        den_next = den_reg;
        esel_next = esel_reg;
        qrem_next = qrem_reg;
        qn_next = qn_reg;
        q_next = q_reg;
        qc_next = qc_reg;
        out_next = out_reg;
        mv_next = (mv_reg && m_ready) ? 1'b0 : mv_reg;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cls_next = s_observed_class;
                    last_next = s_end_of_site;
                    lg_next[0] = s_logit_a;
                    lg_next[1] = s_logit_b;
                    lg_next[2] = s_logit_c;
                    lg_next[3] = s_logit_d;
                    lg_next[4] = s_logit_e;
                    lg_next[5] = s_logit_f;
                    if (s_missing_visit) begin
                        state_next = S_DONE;
                    end else begin
                        // states below the observed class drop out
                        if (mode_reg) begin
                            for (int i = 0; i < 3; i++)
                                if (i < int'(s_observed_class)) prod_next[i] = '0;
                            s_idx_next = (s_observed_class == 2'd0) ? 2'd1 : s_observed_class;
                        end else begin
                            if (s_observed_class != 2'd0) prod_next[0] = '0;
                            s_idx_next = 2'd1;
                        end
                        state_next = S_JOB;
                    end
                end
            end
            S_JOB: begin
                m_next = gmax;
                j_next = 2'd0;
                den_next = '0;
                esel_next = '0;
                state_next = S_EINIT;
            end
            S_EINIT: begin
                d_next = diff[15:0];
                term_next = 41'h100_0000_0000;
                pos_next = 42'h100_0000_0000;
                neg_next = '0;
                k_next = 5'd1;
                state_next = S_MLO;
            end
            S_MLO: begin
                acc_next = 37'(term_reg[20:0]) * 37'(d_reg);
                state_next = S_MHI;
            end
            S_MHI: begin
                dv_next = {7'd0, mhi_sum[56:16]};
                rem_next = '0;
                cnt_next = '0;
                state_next = S_KDIV;
            end
            S_KDIV: begin
                dv_next = {dv_reg[39:0], kq};
                rem_next = krem;
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'd5) begin
                    term_next = dv_next[40:0];
                    if (k_reg[0]) neg_next = neg_reg + 42'(dv_next[40:0]);
                    else pos_next = pos_reg + 42'(dv_next[40:0]);
                    k_next = k_reg + 5'd1;
                    state_next = (k_reg == 5'd16) ? S_EFIN : S_MLO;
                end
            end
            S_EFIN: begin
                sq_next = r_round[41:10];
                cnt_next = '0;
                state_next = S_SQ;
            end
            S_SQ: begin
                sq_next = sq_prod[61:30];
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'd3) state_next = S_ENEXT;
            end
            S_ENEXT: begin
                den_next = den_reg + 34'(sq_reg);
                if (j_reg == sel) esel_next = sq_reg;
                if (j_reg == s_idx_reg) begin
                    state_next = S_QINIT;
                end else begin
                    j_next = j_reg + 2'd1;
                    state_next = S_EINIT;
                end
            end
            S_QINIT: begin
                // numerator esel*2^17 + den split into a head and 17 low bits
                den_next = den_fix;
                qrem_next = 35'(esel_reg) + 35'(den_fix[33:17]);
                qn_next = den_fix[16:0];
                q_next = '0;
                qc_next = '0;
                state_next = S_QDIV;
            end
            S_QDIV: begin
                if (qr >= dd2) begin
                    qrem_next = 35'(qr - dd2);
                    q_next = {q_reg[15:0], 1'b1};
                end else begin
                    qrem_next = qr[34:0];
                    q_next = {q_reg[15:0], 1'b0};
                end
                qn_next = {qn_reg[15:0], 1'b0};
                qc_next = qc_reg + 5'd1;
                if (qc_reg == 5'd16) state_next = S_PMUL;
            end
            S_PMUL: begin
                prod_next[s_idx_reg] = pm[32:16];
                if (s_idx_reg == 2'd3 || !mode_reg) begin
                    state_next = S_DONE;
                end else begin
                    s_idx_next = s_idx_reg + 2'd1;
                    state_next = S_JOB;
                end
            end
            S_DONE: begin
                if (!last_reg) begin
                    state_next = S_IDLE;
                end else if (!mv_reg || m_ready) begin
                    out_next[0] = prod_reg[0];
                    out_next[1] = prod_reg[1];
                    out_next[2] = mode_reg ? prod_reg[2] : '0;
                    out_next[3] = mode_reg ? prod_reg[3] : '0;
                    for (int i = 0; i < 4; i++) prod_next[i] = sdp_pkg::ONE_Q16;
                    mv_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            mode_reg <= 1'b1;
            mv_reg <= 1'b0;
            for (int i = 0; i < 4; i++) prod_reg[i] <= sdp_pkg::ONE_Q16;
        end else begin
            state_reg <= state_next;
            mode_reg <= mode_next;
            mv_reg <= mv_next;
            prod_reg <= prod_next;
        end
    end

    always_ff @(posedge aclk) begin
        cls_reg <= cls_next;
        last_reg <= last_next;
        lg_reg <= lg_next;
        s_idx_reg <= s_idx_next;
        j_reg <= j_next;
        m_reg <= m_next;
        d_reg <= d_next;
        term_reg <= term_next;
        pos_reg <= pos_next;
        neg_reg <= neg_next;
        k_reg <= k_next;
        acc_reg <= acc_next;
        dv_reg <= dv_next;
        rem_reg <= rem_next;
        cnt_reg <= cnt_next;
        sq_reg <= sq_next;
        den_reg <= den_next;
        esel_reg <= esel_next;
        qrem_reg <= qrem_next;
        qn_reg <= qn_next;
        q_reg <= q_next;
        qc_reg <= qc_next;
        out_reg <= out_next;
    end
endmodule

### rtl/sdp_checker.sv
// port-level checks for the softmax detection product, bound to the top level
// depends on sdp_pkg and softmax_detection_product_assert.svh
`include "softmax_detection_product_assert.svh"

module sdp_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_valid,
    input logic                        s_ready,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [sdp_pkg::PROB_W-1:0]  m_prob_state0,
    input logic [sdp_pkg::PROB_W-1:0]  m_prob_state1,
    input logic [sdp_pkg::PROB_W-1:0]  m_prob_state2,
    input logic [sdp_pkg::PROB_W-1:0]  m_prob_state3
);
    logic [4*sdp_pkg::PROB_W-1:0] out_word;
    logic                         out_in_range;

    assign out_word = {m_prob_state0, m_prob_state1, m_prob_state2, m_prob_state3};
    assign out_in_range = (m_prob_state0 <= sdp_pkg::ONE_Q16)
                       && (m_prob_state1 <= sdp_pkg::ONE_Q16)
                       && (m_prob_state2 <= sdp_pkg::ONE_Q16)
                       && (m_prob_state3 <= sdp_pkg::ONE_Q16);

    // a stalled result word holds
    `SDP_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(out_word))
    // products never exceed one
    `SDP_ASSERT_NOW(a_out_range, m_valid, out_in_range)
    // a visit word always keeps the unit busy for the next cycle
    `SDP_ASSERT_NEXT(a_busy, s_valid && s_ready, !s_ready)
endmodule

bind softmax_detection_product sdp_checker u_sdp_checker (.*);

### bench/tb_softmax_detection_product.sv
// testbench for softmax_detection_product: per-site visit words in, product words out
// self-checking against an in-bench fixed-point predictor; depends on sdp_pkg and the rtl
`timescale 1ns / 100ps

module tb_softmax_detection_product;
    localparam int CLS_W   = sdp_pkg::CLS_W;
    localparam int LOGIT_W = sdp_pkg::LOGIT_W;
    localparam int PROB_W  = sdp_pkg::PROB_W;
    localparam logic [PROB_W-1:0] ONE_Q16 = sdp_pkg::ONE_Q16;

    localparam int SETTLE_CYCLES = 2000;

    typedef struct {
        logic [CLS_W-1:0]          cls;
        logic                      missing;
        logic                      last;
        logic signed [LOGIT_W-1:0] lg [6];
    } visit_t;

    typedef struct {
        logic [PROB_W-1:0] p [4];
    } site_probs_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic cfg_wdata = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [CLS_W-1:0] s_observed_class = '0;
    logic s_missing_visit = 1'b0;
    logic s_end_of_site = 1'b0;
    logic signed [15:0] s_logit_a = '0, s_logit_b = '0, s_logit_c = '0;
    logic signed [15:0] s_logit_d = '0, s_logit_e = '0, s_logit_f = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [PROB_W-1:0] m_prob_state0, m_prob_state1, m_prob_state2, m_prob_state3;

    softmax_detection_product u_top (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_observed_class(s_observed_class),
        .s_missing_visit(s_missing_visit), .s_end_of_site(s_end_of_site),
        .s_logit_a(s_logit_a), .s_logit_b(s_logit_b), .s_logit_c(s_logit_c),
        .s_logit_d(s_logit_d), .s_logit_e(s_logit_e), .s_logit_f(s_logit_f),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_prob_state0(m_prob_state0), .m_prob_state1(m_prob_state1),
        .m_prob_state2(m_prob_state2), .m_prob_state3(m_prob_state3)
    );

    visit_t pending_visits [$];
    site_probs_t due_products [$];
    visit_t cur_visit;
    logic [PROB_W-1:0] model_prod [4];
    logic model_four_state = 1'b1;
    int mismatch_count = 0;
    int gap_left = 0;
    int stall_left = 0;
    bit s_took = 0;
    bit quiet = 0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #200_000_000;
        $display("tb_softmax_detection_product: done, errors");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 4);
        return $urandom_range(20, 80);
    endfunction

    // exp(-d/4096) in q.30: series for exp(-d/65536), then four squarings
    function automatic longint unsigned exp_q30(int unsigned d);
        longint unsigned term, pos, neg, r, s;
        term = 64'd1 << 40;
        pos = term;
        neg = 0;
        d = d & 32'hFFFF;
        for (int k = 1; k <= 16; k++) begin
            term = ((term * d) >> 16) / k;
            if (k % 2) neg += term; else pos += term;
        end
        r = (pos > neg) ? pos - neg : 0;
        s = (r + 512) >> 10;
        for (int i = 0; i < 4; i++) s = (s * s + (64'd1 << 29)) >> 30;
        return s;
    endfunction

    // softmax of an implicit zero plus n logits, term sel rounded to q1.16
    function automatic longint unsigned group_term(int n, int x1, int x2, int x3, int sel);
        int v [4];
        int m;
        longint unsigned e [4];
        longint unsigned den;
        v[0] = 0; v[1] = x1; v[2] = x2; v[3] = x3;
        m = 0;
        den = 0;
        for (int j = 1; j <= n; j++) if (v[j] > m) m = v[j];
        for (int j = 0; j <= n; j++) begin
            e[j] = exp_q30(m - v[j]);
            den += e[j];
        end
        if (den == 0) den = 1;
        return ((e[sel] << 17) + den) / (2 * den);
    endfunction

    function automatic void scale_prod(int idx, longint unsigned f);
        longint unsigned p;
        p = model_prod[idx] * f;
        model_prod[idx] = PROB_W'((p + 32768) >> 16);
    endfunction

    task automatic predict_visit(visit_t v);
        int a, b, c, d, e, f;
        site_probs_t res;
        a = int'(v.lg[0]); b = int'(v.lg[1]); c = int'(v.lg[2]);
        d = int'(v.lg[3]); e = int'(v.lg[4]); f = int'(v.lg[5]);
        if (!v.missing) begin
            if (model_four_state) begin
                if (v.cls >= 1) model_prod[0] = '0;
                if (v.cls >= 2) model_prod[1] = '0;
                if (v.cls >= 3) model_prod[2] = '0;
                if (v.cls <= 1) scale_prod(1, group_term(1, a, 0, 0, v.cls == 0 ? 1 : 0));
                if (v.cls <= 2) scale_prod(2, group_term(2, b, c, 0, (v.cls + 1) % 3));
                scale_prod(3, group_term(3, d, e, f, (v.cls + 1) % 4));
            end else if (v.cls == 0) begin
                scale_prod(1, group_term(1, a, 0, 0, 0));
            end else begin
                model_prod[0] = '0;
                scale_prod(1, group_term(1, a, 0, 0, 1));
            end
        end
        if (v.last) begin
            res.p[0] = model_prod[0];
            res.p[1] = model_prod[1];
            res.p[2] = model_four_state ? model_prod[2] : '0;
            res.p[3] = model_four_state ? model_prod[3] : '0;
            due_products.push_back(res);
            for (int k = 0; k < 4; k++) model_prod[k] = ONE_Q16;
        end
    endtask

    // input side: accept at the rising edge, drive at the falling edge
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            predict_visit(cur_visit);
            s_took = 1;
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_took) begin
            s_took = 0;
            if (gap_left > 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (pending_visits.size() > 0) begin
                cur_visit = pending_visits.pop_front();
                s_observed_class <= cur_visit.cls;
                s_missing_visit <= cur_visit.missing;
                s_end_of_site <= cur_visit.last;
                s_logit_a <= cur_visit.lg[0];
                s_logit_b <= cur_visit.lg[1];
                s_logit_c <= cur_visit.lg[2];
                s_logit_d <= cur_visit.lg[3];
                s_logit_e <= cur_visit.lg[4];
                s_logit_f <= cur_visit.lg[5];
                s_valid <= 1'b1;
                gap_left = pick_gap();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result side: random back-pressure
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if (!quiet && $urandom_range(0, 99) < 25)
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 300)
                                                           : $urandom_range(1, 5);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            site_probs_t want;
            logic [PROB_W-1:0] got [4];
            got[0] = m_prob_state0; got[1] = m_prob_state1;
            got[2] = m_prob_state2; got[3] = m_prob_state3;
            if (due_products.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected product word: %0d %0d %0d %0d",
                             got[0], got[1], got[2], got[3]);
            end else begin
                want = due_products.pop_front();
                for (int k = 0; k < 4; k++) begin
                    if (got[k] !== want.p[k]) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("prob_state%0d mismatch: expected %0d, got %0d",
                                     k, want.p[k], got[k]);
                    end
                end
            end
        end
    end

    task automatic add_visit(int cls, bit miss, bit last, int a, int b, int c,
                             int d, int e, int f);
        visit_t v;
        v.cls = CLS_W'(cls); v.missing = miss; v.last = last;
        v.lg[0] = LOGIT_W'(a); v.lg[1] = LOGIT_W'(b); v.lg[2] = LOGIT_W'(c);
        v.lg[3] = LOGIT_W'(d); v.lg[4] = LOGIT_W'(e); v.lg[5] = LOGIT_W'(f);
        pending_visits.push_back(v);
    endtask

    function automatic int rand_logit();
        if ($urandom_range(0, 3) == 0) return $signed(16'($urandom()));
        return $urandom_range(0, 16384) - 8192;
    endfunction

    task automatic add_random(int n_visits, bit close_site);
        int left;
        left = 0;
        for (int i = 0; i < n_visits; i++) begin
            if (left == 0) left = $urandom_range(1, 6);
            left--;
            add_visit($urandom_range(0, 3), $urandom_range(0, 9) == 0,
                      (left == 0) || (close_site && i == n_visits - 1),
                      rand_logit(), rand_logit(), rand_logit(),
                      rand_logit(), rand_logit(), rand_logit());
        end
    endtask

    task automatic drain();
        do begin
            @(negedge aclk);
            #1;
        end while (pending_visits.size() > 0 || s_valid || due_products.size() > 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_mode(bit val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= val;
        model_four_state = val;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        for (int k = 0; k < 4; k++) model_prod[k] = ONE_Q16;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // four-state directed: extremes, every class, skipped visits
        add_visit(0, 0, 1, 0, 0, 0, 0, 0, 0);
        add_visit(0, 0, 0, 32767, 32767, 32767, 32767, 32767, 32767);
        add_visit(1, 0, 1, -32768, -32768, -32768, -32768, -32768, -32768);
        add_visit(2, 0, 0, 32767, -32768, 32767, -32768, 32767, -32768);
        add_visit(3, 0, 1, -1, 4096, -4096, 8192, 0, -8192);
        add_visit(3, 1, 1, 1, 2, 3, 4, 5, 6);
        add_visit(3, 1, 0, 100, 200, 300, 400, 500, 600);
        add_visit(0, 0, 0, -32768, 32767, 0, -32768, 0, 32767);
        add_visit(1, 0, 1, 4096, 4096, 4096, 4096, 4096, 4096);
        add_visit(2, 0, 0, -4096, 0, 0, 0, 0, 0);
        add_visit(3, 0, 1, 0, 0, 0, 32767, 32767, 32767);
        drain();

        // two-state directed
        write_mode(1'b0);
        add_visit(0, 0, 0, 32767, 5, 5, 5, 5, 5);
        add_visit(0, 0, 1, -32768, -1, -1, -1, -1, -1);
        add_visit(1, 0, 0, 32767, 0, 0, 0, 0, 0);
        add_visit(2, 0, 1, -32768, 0, 0, 0, 0, 0);
        add_visit(3, 0, 0, 0, 0, 0, 0, 0, 0);
        add_visit(0, 1, 1, 1234, 0, 0, 0, 0, 0);
        drain();

        // random phases; some leave a site open across a mode change
        add_random(350, 0);
        drain();
        write_mode(1'b1);
        quiet = 1;
        add_random(300, 0);
        drain();
        quiet = 0;
        write_mode(1'b0);
        add_random(400, 1);
        drain();
        write_mode(1'b1);
        add_random(400, 0);
        drain();
        write_mode(1'b0);
        add_random(350, 1);
        drain();

        if (mismatch_count == 0) begin
            $display("tb_softmax_detection_product: done, clean");
        end else begin
            $display("tb_softmax_detection_product: done, errors");
        end
        $finish;
    end
endmodule
